// File: hw/rtl/timestamped_line_field_splitter_core_macros.svh
// assertion macros shared by the splitter checker
`ifndef TIMESTAMPED_LINE_FIELD_SPLITTER_CORE_MACROS_SVH
`define TIMESTAMPED_LINE_FIELD_SPLITTER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define TSFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define TSFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tsfs_pkg.sv
// shared types and constants of the line field splitter
`timescale 1ns / 1ps
`default_nettype none
package tsfs_pkg;

  typedef enum logic [2:0] {
    K_TIME  = 3'd0,
    K_FBYTE = 3'd1,
    K_FEND  = 3'd2,
    K_LEND  = 3'd3,
    K_SHORT = 3'd4
  } kind_e;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] REG_TIME_LEN   = 2'd0;
  localparam logic [1:0] REG_ITEM_LEN   = 2'd1;
  localparam logic [1:0] REG_ITEM_COUNT = 2'd2;

  // effective (capped) register values
  typedef struct packed {
    logic [5:0] prefix_len;
    logic [6:0] slot_len;
    logic [5:0] item_count;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] position;
    logic [7:0] character;
    logic [7:0] field_index;
    logic [7:0] field_length;
    logic       too_long;
    logic [7:0] field_count;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/tsfs_cfg.sv
// configuration registers and their capped values
`timescale 1ns / 1ps
`default_nettype none
module tsfs_cfg import tsfs_pkg::*; #(
  parameter int MAX_TIME_LEN = 32,
  parameter int MAX_ITEM_LEN = 64,
  parameter int MAX_ITEMS    = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i,
  output cfg_t            cfg_o
);

  logic [5:0] prefix_len_q;
  logic [6:0] slot_len_q;
  logic [5:0] item_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_len_q <= 6'd8;
      slot_len_q   <= 7'd16;
      item_count_q <= 6'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TIME_LEN:   prefix_len_q <= cfg_data_i[5:0];
        REG_ITEM_LEN:   slot_len_q   <= cfg_data_i;
        REG_ITEM_COUNT: item_count_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.prefix_len = ({2'b00, prefix_len_q} > 8'(MAX_TIME_LEN)) ?
                       6'(MAX_TIME_LEN) : prefix_len_q;
    cfg_o.slot_len = ({1'b0, slot_len_q} > 8'(MAX_ITEM_LEN)) ?
                     7'(MAX_ITEM_LEN) : slot_len_q;
    // zero slot size acts as one
    if (cfg_o.slot_len == 7'd0) begin
      cfg_o.slot_len = 7'd1;
    end
    cfg_o.item_count = ({2'b00, item_count_q} > 8'(MAX_ITEMS)) ?
                       6'(MAX_ITEMS) : item_count_q;
  end

endmodule
`default_nettype wire

// File: hw/rtl/tsfs_parse.sv
// line state and single-pass decode of one input transaction
`timescale 1ns / 1ps
`default_nettype none
module tsfs_parse import tsfs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eoi_i,
  output logic            push_o,
  output res_t            res_o
);

  localparam logic [1:0] PH_TIME  = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_FIELD = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [5:0] tpos_q, tpos_d;
  logic [7:0] field_q, field_d;
  logic [7:0] len_q, len_d;

  logic       emit;
  logic       in_time, at_skip, is_space, is_tab, is_eol;
  logic [7:0] len_eff, field_inc, len_inc;
  logic [6:0] tpos_inc;
  logic       in_slot, keep, too_long;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  always_comb begin
    in_time   = (phase_q == PH_TIME) && (tpos_q < cfg_i.prefix_len);
    at_skip   = (phase_q == PH_TIME) || (phase_q == PH_SKIP);
    is_space  = (byte_i == CH_SPACE);
    is_tab    = (byte_i == CH_TAB);
    is_eol    = (byte_i == CH_CR) || (byte_i == CH_LF);
    len_eff   = at_skip ? 8'd0 : len_q;
    field_inc = sat_inc(field_q);
    len_inc   = sat_inc(len_eff);
    tpos_inc  = {1'b0, tpos_q} + 7'd1;
    in_slot   = field_q < {2'b00, cfg_i.item_count};
    keep      = in_slot && (len_eff < {1'b0, cfg_i.slot_len - 7'd1});
    too_long  = in_slot && (len_eff > {1'b0, cfg_i.slot_len});

    phase_d = phase_q;
    tpos_d  = tpos_q;
    field_d = field_q;
    len_d   = len_q;
    emit    = 1'b0;
    res_o   = '0;

    if (in_time) begin
      emit           = 1'b1;
      res_o.position = tpos_q;
      if (eoi_i) begin
        res_o.kind = K_SHORT;
        phase_d    = PH_TIME;
        tpos_d     = '0;
        field_d    = '0;
        len_d      = '0;
      end else begin
        res_o.kind      = K_TIME;
        res_o.character = byte_i;
        tpos_d          = tpos_inc[5:0];
        if (tpos_inc >= {1'b0, cfg_i.prefix_len}) begin
          phase_d = PH_SKIP;
        end
      end
    end else if (at_skip && !eoi_i && is_space) begin
      phase_d = PH_SKIP;
    end else if (at_skip && (eoi_i || is_eol || is_tab)) begin
      // empty field closes the line
      emit              = 1'b1;
      res_o.kind        = K_LEND;
      res_o.field_index = field_q;
      res_o.field_count = field_q;
      phase_d           = PH_TIME;
      tpos_d            = '0;
      field_d           = '0;
      len_d             = '0;
    end else if (eoi_i || is_eol) begin
      emit               = 1'b1;
      res_o.kind         = K_LEND;
      res_o.field_index  = field_q;
      res_o.field_length = len_eff;
      res_o.too_long     = too_long;
      res_o.field_count  = field_inc;
      phase_d            = PH_TIME;
      tpos_d             = '0;
      field_d            = '0;
      len_d              = '0;
    end else if (is_space || is_tab) begin
      emit               = 1'b1;
      res_o.kind         = K_FEND;
      res_o.field_index  = field_q;
      res_o.field_length = len_eff;
      res_o.too_long     = too_long;
      field_d            = field_inc;
      len_d              = '0;
      phase_d            = PH_SKIP;
    end else begin
      phase_d = PH_FIELD;
      len_d   = len_inc;
      if (keep) begin
        emit              = 1'b1;
        res_o.kind        = K_FBYTE;
        res_o.position    = len_eff[5:0];
        res_o.character   = byte_i;
        res_o.field_index = field_q;
      end
    end
  end

  assign push_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TIME;
      tpos_q  <= '0;
      field_q <= '0;
      len_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tpos_q  <= tpos_d;
      field_q <= field_d;
      len_q   <= len_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tsfs_skid.sv
// two-entry result buffer between decode and the output channel
`timescale 1ns / 1ps
`default_nettype none
module tsfs_skid import tsfs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      space_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      data_o
);

  logic [1:0] count_q, count_d;
  res_t       head_q, head_d;
  res_t       tail_q, tail_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign data_o  = head_q;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    unique case ({push_i, pop})
      2'b10: begin
        count_d = count_q + 2'd1;
        if (count_q == 2'd0) begin
          head_d = data_i;
        end else begin
          tail_d = data_i;
        end
      end
      2'b01: begin
        count_d = count_q - 2'd1;
        head_d  = tail_q;
      end
      2'b11: begin
        // only reachable with one entry held
        head_d = data_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/timestamped_line_field_splitter_core.sv
// top level of the timestamped line field splitter
//
//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_ready_o    byte_in_i, end_of_input_i
//  result    out        out_valid_o/out_ready_i  kind_o .. field_count_o
//  config    in         cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// one input transaction per cycle while in_ready_o is high; decode is a single
// pass from the line state registers into a two-entry result buffer that registers
// each result, and the buffer depth sets how long the input side rides out a stall
// in_ready_o drops only while both buffer entries are held
// reset clears line state, buffer count and sets registers to 8 / 16 / 8
`timescale 1ns / 1ps
`default_nettype none
module timestamped_line_field_splitter_core import tsfs_pkg::*; #(
  parameter int MAX_TIME_LEN = 32,
  parameter int MAX_ITEM_LEN = 64,
  parameter int MAX_ITEMS    = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      kind_o,
  output logic [5:0]      position_o,
  output logic [7:0]      character_o,
  output logic [7:0]      field_index_o,
  output logic [7:0]      field_length_o,
  output logic            too_long_o,
  output logic [7:0]      field_count_o
);

  cfg_t cfg;
  res_t res, out_res;
  logic push, accept;

  assign accept = in_valid_i && in_ready_o;

  tsfs_cfg #(
    .MAX_TIME_LEN (MAX_TIME_LEN),
    .MAX_ITEM_LEN (MAX_ITEM_LEN),
    .MAX_ITEMS    (MAX_ITEMS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsfs_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .byte_i   (byte_in_i),
    .eoi_i    (end_of_input_i),
    .push_o   (push),
    .res_o    (res)
  );

  tsfs_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign kind_o         = out_res.kind;
  assign position_o     = out_res.position;
  assign character_o    = out_res.character;
  assign field_index_o  = out_res.field_index;
  assign field_length_o = out_res.field_length;
  assign too_long_o     = out_res.too_long;
  assign field_count_o  = out_res.field_count;

endmodule
`default_nettype wire

// File: hw/rtl/tsfs_checker.sv
// port-level checks of the splitter and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "timestamped_line_field_splitter_core_macros.svh"
module tsfs_checker import tsfs_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] kind_o,
  input wire logic [5:0] position_o,
  input wire logic [7:0] character_o,
  input wire logic [7:0] field_index_o,
  input wire logic [7:0] field_length_o,
  input wire logic       too_long_o,
  input wire logic [7:0] field_count_o
);

  // input side only backs off when results are waiting
  `TSFS_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, !in_ready_o, out_valid_o,
                   "input stalled with no result held")

  // a held result stays valid and keeps its kind, position, character, index and count
  `TSFS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(kind_o) && $stable(position_o) &&
                   $stable(character_o) && $stable(field_index_o) &&
                   $stable(field_count_o),
                   "stalled result changed")

  // line end counts either the fields ended so far or one more
  `TSFS_ASSERT_IMP(a_line_count, clk_i, rst_ni, out_valid_o && kind_o == K_LEND,
                   field_count_o == field_index_o || field_count_o == field_index_o + 8'd1,
                   "line end count does not match index")

  // too long means longer than a slot of at least one byte
  `TSFS_ASSERT_IMP(a_too_long_len, clk_i, rst_ni, out_valid_o && too_long_o,
                   (kind_o == K_FEND || kind_o == K_LEND) && field_length_o >= 8'd2,
                   "too long flag on short field")

endmodule

bind timestamped_line_field_splitter_core tsfs_checker u_tsfs_checker (.*);
`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the timestamped line field splitter core
`timescale 1ns / 1ps
module tb;
  import tsfs_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int MAX_TIME_LEN  = 32;
  localparam int MAX_ITEM_LEN  = 64;
  localparam int MAX_ITEMS     = 32;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {LP_PREFIX, LP_GAP, LP_FIELD} line_phase_e;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [1:0] cfg_index_i    = REG_TIME_LEN;
  logic [6:0] cfg_data_i     = '0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] byte_in_i      = '0;
  logic       end_of_input_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [2:0] kind_o;
  logic [5:0] position_o;
  logic [7:0] character_o;
  logic [7:0] field_index_o;
  logic [7:0] field_length_o;
  logic       too_long_o;
  logic [7:0] field_count_o;

  // predictor copy of registers and line state
  logic [5:0]  tlen_reg;
  logic [6:0]  ilen_reg;
  logic [5:0]  icnt_reg;
  line_phase_e line_ph;
  int          prefix_pos;
  logic [7:0]  fld_idx;
  logic [7:0]  fld_len;

  res_t token_q[$];
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles    = 0;
  int   items_sent     = 0;
  int   tokens_checked = 0;
  int   err_count      = 0;
  int   kind_seen[5]   = '{default: 0};

  timestamped_line_field_splitter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_in_i      (byte_in_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .position_o     (position_o),
    .character_o    (character_o),
    .field_index_o  (field_index_o),
    .field_length_o (field_length_o),
    .too_long_o     (too_long_o),
    .field_count_o  (field_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_tlen();
    return (tlen_reg > MAX_TIME_LEN) ? MAX_TIME_LEN : int'(tlen_reg);
  endfunction

  function automatic int eff_ilen();
    int v;
    v = (ilen_reg > MAX_ITEM_LEN) ? MAX_ITEM_LEN : int'(ilen_reg);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int eff_icnt();
    return (icnt_reg > MAX_ITEMS) ? MAX_ITEMS : int'(icnt_reg);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic over_slot();
    return (fld_idx < eff_icnt()) && (fld_len > eff_ilen());
  endfunction

  function automatic void start_line();
    line_ph    = LP_PREFIX;
    prefix_pos = 0;
    fld_idx    = '0;
    fld_len    = '0;
  endfunction

  // advances the line state by one character, returns 1 when a token is due
  function automatic bit split_char(input logic [7:0] c, input logic eoi, output res_t tok);
    logic [7:0] slot;
    tok = '0;
    if (line_ph == LP_PREFIX) begin
      if (prefix_pos < eff_tlen()) begin
        tok.position = prefix_pos[5:0];
        if (eoi) begin
          tok.kind = K_SHORT;
          start_line();
          return 1'b1;
        end
        tok.kind      = K_TIME;
        tok.character = c;
        prefix_pos++;
        if (prefix_pos >= eff_tlen()) line_ph = LP_GAP;
        return 1'b1;
      end
      line_ph = LP_GAP;
    end
    if (line_ph == LP_GAP) begin
      if (!eoi && c == CH_SPACE) return 1'b0;
      if (eoi || c == CH_CR || c == CH_LF || c == CH_TAB) begin
        // empty field closes the line
        tok.kind        = K_LEND;
        tok.field_index = fld_idx;
        tok.field_count = fld_idx;
        start_line();
        return 1'b1;
      end
      line_ph = LP_FIELD;
      fld_len = '0;
    end
    if (eoi || c == CH_CR || c == CH_LF) begin
      tok.kind         = K_LEND;
      tok.field_index  = fld_idx;
      tok.field_length = fld_len;
      tok.too_long     = over_slot();
      tok.field_count  = sat_inc(fld_idx);
      start_line();
      return 1'b1;
    end
    if (c == CH_SPACE || c == CH_TAB) begin
      tok.kind         = K_FEND;
      tok.field_index  = fld_idx;
      tok.field_length = fld_len;
      tok.too_long     = over_slot();
      fld_idx = sat_inc(fld_idx);
      fld_len = '0;
      line_ph = LP_GAP;
      return 1'b1;
    end
    slot    = fld_len;
    fld_len = sat_inc(fld_len);
    if (fld_idx < eff_icnt() && slot < eff_ilen() - 1) begin
      tok.kind        = K_FBYTE;
      tok.position    = slot[5:0];
      tok.character   = c;
      tok.field_index = fld_idx;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic string token_text(input res_t t);
    return $sformatf("kind %0d pos %0d char %02h idx %0d len %0d too_long %0b count %0d",
                     t.kind, t.position, t.character, t.field_index, t.field_length,
                     t.too_long, t.field_count);
  endfunction

  // ------------------------------------------------------- result side

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {kind_o, position_o, character_o, field_index_o, field_length_o,
             too_long_o, field_count_o};
      tokens_checked++;
      if (kind_o <= K_SHORT) kind_seen[kind_o]++;
      if (token_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: result with none expected: %s", $time, token_text(got));
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $time);
            $display("  expected %s", token_text(want));
            $display("  actual   %s", token_text(got));
          end
        end
      end
    end
  end

  // ------------------------------------------------------- input side

  task automatic send_char(input logic [7:0] b, input logic eoi);
    int   gap;
    res_t tok;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_in_i      <= b;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    if (split_char(b, eoi, tok)) token_q.push_back(tok);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // the byte is ignored with end of input, so it is random
  task automatic send_eoi();
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    // a character that makes no token may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TIME_LEN:   tlen_reg = data[5:0];
      REG_ITEM_LEN:   ilen_reg = data;
      REG_ITEM_COUNT: icnt_reg = data[5:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_LF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic randomise_setup();
    logic [6:0] v;
    case ($urandom_range(7))
      0: v = 7'd0;
      1: v = 7'd32;
      2: v = 7'($urandom_range(127, 33));
      default: v = 7'($urandom_range(6, 1));
    endcase
    write_reg(REG_TIME_LEN, v);
    case ($urandom_range(7))
      0: v = 7'd0;
      1: v = 7'd1;
      2: v = 7'd64;
      3: v = 7'($urandom_range(127, 65));
      default: v = 7'($urandom_range(10, 2));
    endcase
    write_reg(REG_ITEM_LEN, v);
    case ($urandom_range(7))
      0: v = 7'd0;
      1: v = 7'd32;
      2: v = 7'($urandom_range(127, 33));
      default: v = 7'($urandom_range(5, 1));
    endcase
    write_reg(REG_ITEM_COUNT, v);
  endtask

  task automatic send_random_line();
    int nf;
    int len;
    int lim;
    int f;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(12, 1)) begin
        if ($urandom_range(19) == 0) send_eoi();
        else send_char(noise_byte(), 1'b0);
      end
    end else if (eff_tlen() > 0 && $urandom_range(29) == 0) begin
      // line cut short inside the time prefix
      repeat ($urandom_range(eff_tlen() - 1, 0)) send_char(8'($urandom_range(255)), 1'b0);
      send_eoi();
    end else begin
      repeat (eff_tlen()) send_char(8'($urandom_range(255)), 1'b0);
      repeat ($urandom_range(2, 0)) send_char(CH_SPACE, 1'b0);
      lim = (eff_icnt() + 2 > 8) ? 8 : eff_icnt() + 2;
      nf  = $urandom_range(lim, 0);
      for (f = 0; f < nf; f++) begin
        lim = ($urandom_range(9) == 0) ? eff_ilen() + 2 : 8;
        len = $urandom_range(lim, 1);
        repeat (len) send_char(text_byte(), 1'b0);
        if (f < nf - 1) begin
          case ($urandom_range(3))
            0: send_char(CH_SPACE, 1'b0);
            1: repeat ($urandom_range(3, 1)) send_char(CH_SPACE, 1'b0);
            2: send_char(CH_TAB, 1'b0);
            default: begin
              send_char(CH_TAB, 1'b0);
              repeat ($urandom_range(2, 1)) send_char(CH_SPACE, 1'b0);
            end
          endcase
        end
      end
      case ($urandom_range(6))
        0: send_char(CH_CR, 1'b0);
        1: send_char(CH_LF, 1'b0);
        2: begin
          send_char(CH_CR, 1'b0);
          send_char(CH_LF, 1'b0);
        end
        3: begin
          repeat ($urandom_range(3, 1)) send_char(CH_SPACE, 1'b0);
          send_char(CH_CR, 1'b0);
        end
        4: send_eoi();
        5: begin
          send_char(CH_SPACE, 1'b0);
          send_eoi();
        end
        default: begin
          send_char(CH_TAB, 1'b0);
          send_char(CH_LF, 1'b0);
        end
      endcase
    end
  endtask

  // ------------------------------------------------------- tests

  task automatic test_reset_prefix();
    send_text("00:00:00");
    send_text("k");
    send_char(CH_LF, 1'b0);
  endtask

  task automatic test_separators_and_line_ends();
    write_reg(REG_TIME_LEN, 7'd0);
    write_reg(REG_ITEM_LEN, 7'd3);
    write_reg(REG_ITEM_COUNT, 7'd2);
    // over-long first field closed by a tab, third field outside the slots
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h7F, 1'b0);
    send_text("z");
    send_char(CH_TAB, 1'b0);
    send_text("ab");
    send_char(CH_SPACE, 1'b0);
    send_text("c");
    send_char(CH_CR, 1'b0);
    // empty field after spaces, closed by LF
    send_text("x");
    send_char(CH_SPACE, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_text("y");
    send_eoi();
    send_text("y");
    send_char(CH_SPACE, 1'b0);
    send_eoi();
    send_char(CH_CR, 1'b0);
    send_text("z");
    send_char(CH_LF, 1'b0);
    drain_results();
  endtask

  task automatic test_register_limits();
    write_reg(REG_UNUSED, 7'h7F);
    write_reg(REG_TIME_LEN, 7'd3);
    send_text("ab");
    send_eoi();
    // slot size zero keeps no bytes, item count above the cap
    write_reg(REG_TIME_LEN, 7'd0);
    write_reg(REG_ITEM_LEN, 7'd0);
    write_reg(REG_ITEM_COUNT, 7'd63);
    send_text("ab");
    send_char(CH_SPACE, 1'b0);
    send_text("c");
    send_char(CH_LF, 1'b0);
    write_reg(REG_TIME_LEN, 7'd63);
    write_reg(REG_ITEM_LEN, 7'd127);
    write_reg(REG_ITEM_COUNT, 7'd0);
    repeat (MAX_TIME_LEN) send_char(8'($urandom_range(255)), 1'b0);
    send_text("q");
    send_char(CH_CR, 1'b0);
    // prefix shortened below the current position mid-line
    write_reg(REG_TIME_LEN, 7'd8);
    write_reg(REG_ITEM_COUNT, 7'd4);
    send_text("12:34");
    write_reg(REG_TIME_LEN, 7'd3);
    write_reg(REG_UNUSED, 7'h00);
    send_text("k");
    send_char(CH_LF, 1'b0);
    drain_results();
  endtask

  task automatic test_saturation();
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    write_reg(REG_TIME_LEN, 7'd0);
    write_reg(REG_ITEM_LEN, 7'd64);
    write_reg(REG_ITEM_COUNT, 7'd32);
    repeat (260) send_char(text_byte(), 1'b0);
    send_char(CH_LF, 1'b0);
    repeat (256) begin
      send_text("a");
      send_char(CH_SPACE, 1'b0);
    end
    send_text("a");
    send_char(CH_CR, 1'b0);
    drain_results();
  endtask

  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_TIME_LEN, 7'd32);
    write_reg(REG_ITEM_LEN, 7'd16);
    write_reg(REG_ITEM_COUNT, 7'd8);
    // receiver holds off while every character makes a token
    hold_cycles = 200;
    repeat (MAX_TIME_LEN) send_char(8'($urandom_range(255)), 1'b0);
    send_text("abcd");
    send_char(CH_LF, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int stop_at;
    randomise_setup();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      send_random_line();
      if ($urandom_range(29) == 0) randomise_setup();
    end
    drain_results();
  endtask

  initial begin
    int n;
    tlen_reg = 6'd8;
    ilen_reg = 7'd16;
    icnt_reg = 6'd8;
    start_line();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_prefix();
    test_separators_and_line_ends();
    test_register_limits();
    test_saturation();
    test_back_pressure();
    test_random_traffic(220, 0, 0);
    test_random_traffic(220, 85, 0);
    test_random_traffic(220, 0, 85);
    test_random_traffic(220, 29, 29);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_valid_i <= 1'b0;
    for (n = 0; n < 5000 && token_q.size() != 0; n++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (token_q.size() != 0) $display("%0d expected results never arrived", token_q.size());
    $display("summary: %0d characters in, %0d tokens out across prefix, slot and count limits",
             items_sent, tokens_checked);
    $display("summary: time %0d, field byte %0d, field end %0d, line end %0d, short %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (err_count == 0 && token_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d tokens outstanding", token_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
